// ===== rtl/cfl_tsr_pkg.sv =====
// Package for the CFL timestep min-reduce block: widths, codes, reset values
// and the command/status structs between the controller and the datapath.
// No dependencies.
package cfl_tsr_pkg;

   // Fixed field widths of the channels
   localparam int DATA_WIDTH      = 48;
   localparam int OUT_WIDTH       = 47;
   localparam int OPCODE_WIDTH    = 2;

   // Default number format
   localparam int DEF_VALUE_WIDTH = 48;
   localparam int DEF_FRAC_BITS   = 24;

   // Configuration registers (Q24 as written)
   localparam int REG_FRAC        = 24;
   localparam int GAMMA_WIDTH     = 26;
   localparam int COURANT_WIDTH   = 25;
   localparam int CSR_DATA_WIDTH  = 26;
   localparam int CSR_INDEX_WIDTH = 1;
   localparam logic [GAMMA_WIDTH-1:0]     GAMMA_RESET   = 26'd23488102;
   localparam logic [COURANT_WIDTH-1:0]   COURANT_RESET = 25'd8388608;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_GAMMA     = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_COURANT   = 1'b1;

   // Request opcodes
   localparam logic [OPCODE_WIDTH-1:0] OP_CELL  = 2'd0;
   localparam logic [OPCODE_WIDTH-1:0] OP_FACE  = 2'd1;
   localparam logic [OPCODE_WIDTH-1:0] OP_CLEAR = 2'd2;

   // Shared arithmetic unit operations
   typedef enum logic [1:0] {
      ARITH_MUL,
      ARITH_DIV,
      ARITH_SQRT
   } arith_op_type;

   // Sequencer steps: cell chain, then face chain, then last-face tail
   typedef enum logic [4:0] {
      STEP_U0, STEP_U1, STEP_U2,
      STEP_K0, STEP_K1, STEP_K2, STEP_KR,
      STEP_P, STEP_T, STEP_Q, STEP_C,
      STEP_A0, STEP_A1, STEP_A2, STEP_AR,
      STEP_D0, STEP_D1, STEP_D2, STEP_CT,
      STEP_N, STEP_DT
   } step_type;

   typedef struct packed {
      logic     ready;   // request channel ready
      logic     load;    // latch the accepted request
      logic     start;   // launch the arithmetic unit
      logic     wb;      // write back the unit result
      logic     emit;    // load the response register
      step_type step;
   } cmd_type;

   typedef struct packed {
      logic                    req_valid;
      logic [OPCODE_WIDTH-1:0] req_opcode;
      logic                    unit_done;
      logic                    last_face;
      logic                    out_busy;
   } status_type;

endpackage

// ===== rtl/cfl_tsr_if.sv =====
// Request and response channel interfaces of the CFL timestep block.
// Depends on cfl_tsr_pkg for the field widths.
interface cfl_tsr_req_if;
   logic                                  valid;
   logic                                  ready;
   logic [cfl_tsr_pkg::OPCODE_WIDTH-1:0]  opcode;
   logic signed [cfl_tsr_pkg::DATA_WIDTH-1:0] density;
   logic signed [cfl_tsr_pkg::DATA_WIDTH-1:0] momentum_x;
   logic signed [cfl_tsr_pkg::DATA_WIDTH-1:0] momentum_y;
   logic signed [cfl_tsr_pkg::DATA_WIDTH-1:0] momentum_z;
   logic signed [cfl_tsr_pkg::DATA_WIDTH-1:0] total_energy;
   logic signed [cfl_tsr_pkg::DATA_WIDTH-1:0] cell_volume;
   logic signed [cfl_tsr_pkg::DATA_WIDTH-1:0] face_ax;
   logic signed [cfl_tsr_pkg::DATA_WIDTH-1:0] face_ay;
   logic signed [cfl_tsr_pkg::DATA_WIDTH-1:0] face_az;
   logic                                  last_face;

   modport source (output valid, opcode, density, momentum_x, momentum_y, momentum_z,
                   total_energy, cell_volume, face_ax, face_ay, face_az, last_face,
                   input ready);
   modport sink (input valid, opcode, density, momentum_x, momentum_y, momentum_z,
                 total_energy, cell_volume, face_ax, face_ay, face_az, last_face,
                 output ready);
endinterface

interface cfl_tsr_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [cfl_tsr_pkg::OUT_WIDTH-1:0]  cell_timestep;
   logic [cfl_tsr_pkg::OUT_WIDTH-1:0]  running_min_timestep;
   logic                               cell_counted;

   modport source (output valid, cell_timestep, running_min_timestep, cell_counted,
                   input ready);
   modport sink (input valid, cell_timestep, running_min_timestep, cell_counted,
                 output ready);
endinterface

// ===== rtl/cfl_tsr_arith.sv =====
// Shared iterative arithmetic unit: shift-add multiply, restoring divide with
// saturation, and digit-by-digit floor square root, one bit per cycle.
// Depends on cfl_tsr_pkg.
module cfl_tsr_arith #(
   parameter int W = cfl_tsr_pkg::DEF_VALUE_WIDTH
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  cfl_tsr_pkg::arith_op_type op,
   input  logic [2*W-1:0]            opnd_a,
   input  logic [W-1:0]              opnd_b,
   output logic                      done,
   output logic [2*W-1:0]            result
);
   import cfl_tsr_pkg::*;

   localparam int CW = $clog2(W + 1);
   localparam logic [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};

   arith_op_type   op_ff, op_in;
   logic [2*W-1:0] acc_ff, acc_in;
   logic [W-1:0]   opa_ff, opa_in;
   logic [W-1:0]   opb_ff, opb_in;
   logic [W+1:0]   rem_ff, rem_in;
   logic [CW-1:0]  cnt_ff, cnt_in;
   logic           run_ff, run_in;
   logic           done_ff, done_in;
   logic           sat_ff, sat_in;

   logic [W:0]     mul_sum;
   logic [W:0]     div_t;
   logic           div_ge;
   logic           div_ovf;
   logic [W+1:0]   sq_t;
   logic [W+1:0]   sq_trial;
   logic           sq_ge;

   // one iteration of each operation
   assign mul_sum  = {1'b0, acc_ff[2*W-1:W]} + (opb_ff[0] ? {1'b0, opa_ff} : '0);
   assign div_t    = {rem_ff[W-1:0], acc_ff[W-2]};
   assign div_ge   = div_t >= {1'b0, opa_ff};
   assign div_ovf  = (opnd_b == '0) || (opnd_a[2*W-1:W-1] >= {1'b0, opnd_b});
   assign sq_t     = {rem_ff[W-1:0], acc_ff[2*W-1:2*W-2]};
   assign sq_trial = {opb_ff, 2'b01};
   assign sq_ge    = sq_t >= sq_trial;

   // iteration control
   always_comb begin
      op_in   = op_ff;
      acc_in  = acc_ff;
      opa_in  = opa_ff;
      opb_in  = opb_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      sat_in  = sat_ff;
      done_in = 1'b0;
      if (start) begin
         op_in  = op;
         run_in = 1'b1;
         sat_in = 1'b0;
         opb_in = '0;
         rem_in = '0;
         acc_in = opnd_a;
         opa_in = opnd_b;
         cnt_in = CW'(W);
         unique case (op)
            ARITH_MUL: begin
               acc_in = '0;
               opa_in = opnd_a[W-1:0];
               opb_in = opnd_b;
            end
            ARITH_DIV: begin
               rem_in = (W+2)'(opnd_a[2*W-1:W-1]);
               cnt_in = CW'(W - 1);
               if (div_ovf) begin
                  sat_in  = 1'b1;
                  run_in  = 1'b0;
                  done_in = 1'b1;
               end
            end
            ARITH_SQRT: begin
            end
            default: begin
            end
         endcase
      end else if (run_ff) begin
         unique case (op_ff)
            ARITH_MUL: begin
               acc_in = {mul_sum, acc_ff[W-1:1]};
               opb_in = opb_ff >> 1;
            end
            ARITH_DIV: begin
               rem_in = div_ge ? (W+2)'(div_t - {1'b0, opa_ff}) : (W+2)'(div_t);
               acc_in = acc_ff << 1;
               opb_in = {opb_ff[W-2:0], div_ge};
            end
            ARITH_SQRT: begin
               rem_in = sq_ge ? (sq_t - sq_trial) : sq_t;
               acc_in = acc_ff << 2;
               opb_in = {opb_ff[W-2:0], sq_ge};
            end
            default: begin
            end
         endcase
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
         op_ff   <= ARITH_MUL;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
         op_ff   <= op_in;
      end
      acc_ff <= acc_in;
      opa_ff <= opa_in;
      opb_ff <= opb_in;
      rem_ff <= rem_in;
      sat_ff <= sat_in;
   end

   // result select, saturated for quotient and root
   always_comb begin
      unique case (op_ff)
         ARITH_MUL:  result = acc_ff;
         ARITH_DIV:  result = (2*W)'(sat_ff ? VMAX : opb_ff);
         ARITH_SQRT: result = (2*W)'(opb_ff[W-1] ? VMAX : opb_ff);
         default:    result = acc_ff;
      endcase
   end

   assign done = done_ff;

endmodule

// ===== rtl/cfl_tsr_dpath.sv =====
// Datapath of the CFL timestep block: request latch, per-cell state, operand
// select for the shared arithmetic unit, write-back, response register, CSRs.
// Depends on cfl_tsr_pkg, cfl_tsr_if and cfl_tsr_arith.
module cfl_tsr_dpath #(
   parameter int W = cfl_tsr_pkg::DEF_VALUE_WIDTH,
   parameter int F = cfl_tsr_pkg::DEF_FRAC_BITS
) (
   input  logic                                         clock,
   input  logic                                         reset,
   cfl_tsr_req_if.sink                                  req_if,
   cfl_tsr_rsp_if.source                                rsp_if,
   input  logic                                         csr_write_en,
   input  logic [cfl_tsr_pkg::CSR_INDEX_WIDTH-1:0]      csr_index,
   input  logic [cfl_tsr_pkg::CSR_DATA_WIDTH-1:0]       csr_write_data,
   input  cfl_tsr_pkg::cmd_type                         cmd,
   output cfl_tsr_pkg::status_type                      stat
);
   import cfl_tsr_pkg::*;

   localparam logic [W-1:0] VMAX  = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0] ONE_Q = W'(1) << F;
   localparam int DW = 2*W - F + 3;
   localparam int unsigned SHL = (F >= REG_FRAC) ? (F - REG_FRAC) : 0;
   localparam int unsigned SHR = (F >= REG_FRAC) ? 0 : (REG_FRAC - F);

   function automatic logic [W-1:0] sat_w(input logic [2*W-1:0] x);
      if (|x[2*W-1:W-1]) return VMAX;
      return x[W-1:0];
   endfunction

   function automatic logic [W-1:0] sadd(input logic [W-1:0] a, input logic [W-1:0] b);
      logic [W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return (s[W] | s[W-1]) ? VMAX : s[W-1:0];
   endfunction

   // {sign, magnitude} of a signed field
   function automatic logic [W:0] dec(input logic [DATA_WIDTH-1:0] f);
      logic [W-1:0] v;
      v = W'(f);
      return {v[W-1], v[W-1] ? (~v + W'(1)) : v};
   endfunction

   // configuration
   logic [GAMMA_WIDTH-1:0]   gamma_ff, gamma_in;
   logic [COURANT_WIDTH-1:0] courant_ff, courant_in;
   // latched request
   logic [W-1:0] rho_ff, rho_in;
   logic [W-1:0] itm_mag_ff [3];
   logic [W-1:0] itm_mag_in [3];
   logic [2:0]   itm_neg_ff, itm_neg_in;
   logic [W-1:0] te_mag_ff, te_mag_in;
   logic         te_neg_ff, te_neg_in;
   logic         last_ff, last_in;
   // cell state
   logic [W-1:0] u_mag_ff [3];
   logic [W-1:0] u_mag_in [3];
   logic [2:0]   u_neg_ff, u_neg_in;
   logic [W-1:0] c_ff, c_in;
   logic [W-1:0] absvol_ff, absvol_in;
   logic [W-1:0] denom_ff, denom_in;
   logic [W-1:0] min_ff, min_in;
   // scratch
   logic [W-1:0]          ke_ff, ke_in;
   logic [W-1:0]          tmp_ff, tmp_in;
   logic [2*W-1:0]        s_ff, s_in;
   logic [W-1:0]          area_ff, area_in;
   logic signed [DW-1:0]  dot_ff, dot_in;
   logic [W-1:0]          dt_ff, dt_in;
   logic                  counted_ff, counted_in;
   // response register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [OUT_WIDTH-1:0]  rsp_dt_ff, rsp_dt_in;
   logic [OUT_WIDTH-1:0]  rsp_min_ff, rsp_min_in;
   logic                  rsp_cnt_ff, rsp_cnt_in;

   // unit connection
   arith_op_type   u_op;
   logic [2*W-1:0] u_a;
   logic [W-1:0]   u_b;
   logic           u_done;
   logic [2*W-1:0] u_res;

   // derived values
   logic [W-1:0]         gamma_q, gm1, courant_q, e_val, prod_q, dot_sat, new_min;
   logic signed [DW-1:0] pr, dabs;
   logic [W:0]           d_rho, d_mx, d_my, d_mz, d_te, d_vol, d_ax, d_ay, d_az;

   assign gamma_q   = (W'(gamma_ff) << SHL) >> SHR;
   assign courant_q = (W'(courant_ff) << SHL) >> SHR;
   assign gm1       = (gamma_q > ONE_Q) ? (gamma_q - ONE_Q) : '0;
   assign e_val     = (!te_neg_ff && te_mag_ff > ke_ff) ? (te_mag_ff - ke_ff) : '0;
   assign prod_q    = sat_w(u_res >> F);
   assign pr        = $signed(DW'(u_res >> F));
   assign dabs      = dot_ff[DW-1] ? -dot_ff : dot_ff;
   assign dot_sat   = sat_w((2*W)'($unsigned(dabs)));
   assign new_min   = (counted_ff && dt_ff < min_ff) ? dt_ff : min_ff;

   assign d_rho = dec($unsigned(req_if.density));
   assign d_mx  = dec($unsigned(req_if.momentum_x));
   assign d_my  = dec($unsigned(req_if.momentum_y));
   assign d_mz  = dec($unsigned(req_if.momentum_z));
   assign d_te  = dec($unsigned(req_if.total_energy));
   assign d_vol = dec($unsigned(req_if.cell_volume));
   assign d_ax  = dec($unsigned(req_if.face_ax));
   assign d_ay  = dec($unsigned(req_if.face_ay));
   assign d_az  = dec($unsigned(req_if.face_az));

   // operand select per step
   always_comb begin
      u_op = ARITH_MUL;
      u_a  = '0;
      u_b  = '0;
      unique case (cmd.step)
         STEP_U0: begin u_op = ARITH_DIV; u_a = (2*W)'(itm_mag_ff[0]) << F; u_b = rho_ff; end
         STEP_U1: begin u_op = ARITH_DIV; u_a = (2*W)'(itm_mag_ff[1]) << F; u_b = rho_ff; end
         STEP_U2: begin u_op = ARITH_DIV; u_a = (2*W)'(itm_mag_ff[2]) << F; u_b = rho_ff; end
         STEP_K0: begin u_a = (2*W)'(u_mag_ff[0]); u_b = u_mag_ff[0]; end
         STEP_K1: begin u_a = (2*W)'(u_mag_ff[1]); u_b = u_mag_ff[1]; end
         STEP_K2: begin u_a = (2*W)'(u_mag_ff[2]); u_b = u_mag_ff[2]; end
         STEP_KR: begin u_a = (2*W)'(rho_ff); u_b = ke_ff; end
         STEP_P:  begin u_a = (2*W)'(gm1); u_b = e_val; end
         STEP_T:  begin u_a = (2*W)'(gamma_q); u_b = tmp_ff; end
         STEP_Q:  begin u_op = ARITH_DIV; u_a = (2*W)'(tmp_ff) << F; u_b = rho_ff; end
         STEP_C:  begin u_op = ARITH_SQRT; u_a = (2*W)'(tmp_ff) << F; end
         STEP_A0: begin u_a = (2*W)'(itm_mag_ff[0]); u_b = itm_mag_ff[0]; end
         STEP_A1: begin u_a = (2*W)'(itm_mag_ff[1]); u_b = itm_mag_ff[1]; end
         STEP_A2: begin u_a = (2*W)'(itm_mag_ff[2]); u_b = itm_mag_ff[2]; end
         STEP_AR: begin u_op = ARITH_SQRT; u_a = s_ff; end
         STEP_D0: begin u_a = (2*W)'(u_mag_ff[0]); u_b = itm_mag_ff[0]; end
         STEP_D1: begin u_a = (2*W)'(u_mag_ff[1]); u_b = itm_mag_ff[1]; end
         STEP_D2: begin u_a = (2*W)'(u_mag_ff[2]); u_b = itm_mag_ff[2]; end
         STEP_CT: begin u_a = (2*W)'(c_ff); u_b = area_ff; end
         STEP_N:  begin u_a = (2*W)'(courant_q); u_b = absvol_ff; end
         STEP_DT: begin u_op = ARITH_DIV; u_a = s_ff; u_b = denom_ff; end
         default: begin end
      endcase
   end

   cfl_tsr_arith #(.W(W)) u_arith (
      .clock  (clock),
      .reset  (reset),
      .start  (cmd.start),
      .op     (u_op),
      .opnd_a (u_a),
      .opnd_b (u_b),
      .done   (u_done),
      .result (u_res)
   );

   // next-state of all datapath registers
   always_comb begin
      gamma_in     = gamma_ff;
      courant_in   = courant_ff;
      rho_in       = rho_ff;
      itm_mag_in   = itm_mag_ff;
      itm_neg_in   = itm_neg_ff;
      te_mag_in    = te_mag_ff;
      te_neg_in    = te_neg_ff;
      last_in      = last_ff;
      u_mag_in     = u_mag_ff;
      u_neg_in     = u_neg_ff;
      c_in         = c_ff;
      absvol_in    = absvol_ff;
      denom_in     = denom_ff;
      min_in       = min_ff;
      ke_in        = ke_ff;
      tmp_in       = tmp_ff;
      s_in         = s_ff;
      area_in      = area_ff;
      dot_in       = dot_ff;
      dt_in        = dt_ff;
      counted_in   = counted_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_dt_in    = rsp_dt_ff;
      rsp_min_in   = rsp_min_ff;
      rsp_cnt_in   = rsp_cnt_ff;

      // configuration writes
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_GAMMA:   gamma_in   = csr_write_data[GAMMA_WIDTH-1:0];
            CSR_COURANT: courant_in = csr_write_data[COURANT_WIDTH-1:0];
            default: begin end
         endcase
      end

      // request latch
      if (cmd.load) begin
         unique case (req_if.opcode)
            OP_CELL: begin
               rho_in        = (d_rho[W] || d_rho[W-1:0] == '0) ? W'(1) : d_rho[W-1:0];
               itm_mag_in[0] = d_mx[W-1:0];
               itm_mag_in[1] = d_my[W-1:0];
               itm_mag_in[2] = d_mz[W-1:0];
               itm_neg_in    = {d_mz[W], d_my[W], d_mx[W]};
               te_mag_in     = d_te[W-1:0];
               te_neg_in     = d_te[W];
               absvol_in     = d_vol[W-1] ? VMAX : d_vol[W-1:0];
               denom_in      = '0;
            end
            OP_FACE: begin
               itm_mag_in[0] = d_ax[W-1:0];
               itm_mag_in[1] = d_ay[W-1:0];
               itm_mag_in[2] = d_az[W-1:0];
               itm_neg_in    = {d_az[W], d_ay[W], d_ax[W]};
               last_in       = req_if.last_face;
            end
            OP_CLEAR: min_in = VMAX;
            default: begin end
         endcase
      end

      // unit write-back
      if (cmd.wb) begin
         unique case (cmd.step)
            STEP_U0: begin u_mag_in[0] = u_res[W-1:0]; u_neg_in[0] = itm_neg_ff[0]; end
            STEP_U1: begin u_mag_in[1] = u_res[W-1:0]; u_neg_in[1] = itm_neg_ff[1]; end
            STEP_U2: begin u_mag_in[2] = u_res[W-1:0]; u_neg_in[2] = itm_neg_ff[2]; end
            STEP_K0: ke_in = prod_q;
            STEP_K1, STEP_K2: ke_in = sadd(ke_ff, prod_q);
            STEP_KR: ke_in = sat_w(u_res >> (F + 1));
            STEP_P, STEP_T: tmp_in = prod_q;
            STEP_Q:  tmp_in = u_res[W-1:0];
            STEP_C:  c_in = u_res[W-1:0];
            STEP_A0: s_in = u_res;
            STEP_A1, STEP_A2: s_in = s_ff + u_res;
            STEP_AR: area_in = u_res[W-1:0];
            STEP_D0: dot_in = (u_neg_ff[0] != itm_neg_ff[0]) ? -pr : pr;
            STEP_D1: dot_in = (u_neg_ff[1] != itm_neg_ff[1]) ? dot_ff - pr : dot_ff + pr;
            STEP_D2: dot_in = (u_neg_ff[2] != itm_neg_ff[2]) ? dot_ff - pr : dot_ff + pr;
            STEP_CT: begin
               if (area_ff != '0) denom_in = sadd(denom_ff, sadd(dot_sat, prod_q));
            end
            STEP_N:  s_in = u_res;
            STEP_DT: begin
               if (absvol_ff != '0 && denom_ff != '0) begin
                  dt_in      = u_res[W-1:0];
                  counted_in = 1'b1;
               end else begin
                  dt_in      = VMAX;
                  counted_in = 1'b0;
               end
            end
            default: begin end
         endcase
      end

      // response register
      if (rsp_valid_ff && rsp_if.ready) rsp_valid_in = 1'b0;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         rsp_dt_in    = OUT_WIDTH'(dt_ff);
         rsp_min_in   = OUT_WIDTH'(new_min);
         rsp_cnt_in   = counted_ff;
         min_in       = new_min;
         denom_in     = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gamma_ff     <= GAMMA_RESET;
         courant_ff   <= COURANT_RESET;
         u_mag_ff[0]  <= '0;
         u_mag_ff[1]  <= '0;
         u_mag_ff[2]  <= '0;
         u_neg_ff     <= '0;
         c_ff         <= '0;
         absvol_ff    <= '0;
         denom_ff     <= '0;
         min_ff       <= VMAX;
         rsp_valid_ff <= 1'b0;
      end else begin
         gamma_ff     <= gamma_in;
         courant_ff   <= courant_in;
         u_mag_ff     <= u_mag_in;
         u_neg_ff     <= u_neg_in;
         c_ff         <= c_in;
         absvol_ff    <= absvol_in;
         denom_ff     <= denom_in;
         min_ff       <= min_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rho_ff     <= rho_in;
      itm_mag_ff <= itm_mag_in;
      itm_neg_ff <= itm_neg_in;
      te_mag_ff  <= te_mag_in;
      te_neg_ff  <= te_neg_in;
      last_ff    <= last_in;
      ke_ff      <= ke_in;
      tmp_ff     <= tmp_in;
      s_ff       <= s_in;
      area_ff    <= area_in;
      dot_ff     <= dot_in;
      dt_ff      <= dt_in;
      counted_ff <= counted_in;
      rsp_dt_ff  <= rsp_dt_in;
      rsp_min_ff <= rsp_min_in;
      rsp_cnt_ff <= rsp_cnt_in;
   end

   // ports and status
   assign req_if.ready                = cmd.ready;
   assign rsp_if.valid                = rsp_valid_ff;
   assign rsp_if.cell_timestep        = rsp_dt_ff;
   assign rsp_if.running_min_timestep = rsp_min_ff;
   assign rsp_if.cell_counted         = rsp_cnt_ff;

   assign stat.req_valid  = req_if.valid;
   assign stat.req_opcode = req_if.opcode;
   assign stat.unit_done  = u_done;
   assign stat.last_face  = last_ff;
   assign stat.out_busy   = rsp_valid_ff && !rsp_if.ready;

endmodule

// ===== rtl/cfl_tsr_ctrl.sv =====
// Controller of the CFL timestep block: accepts requests and steps through
// the arithmetic sequence for cell and face requests.
// Depends on cfl_tsr_pkg.
module cfl_tsr_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  cfl_tsr_pkg::status_type stat,
   output cfl_tsr_pkg::cmd_type    cmd
);
   import cfl_tsr_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_ISSUE = 4'b0010,
      ST_BUSY  = 4'b0100,
      ST_OUT   = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   step_type  step_ff, step_in;

   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      cmd.ready = 1'b0;
      cmd.load  = 1'b0;
      cmd.start = 1'b0;
      cmd.wb    = 1'b0;
      cmd.emit  = 1'b0;
      cmd.step  = step_ff;
      unique case (state_ff)
         // wait for a request
         ST_IDLE: begin
            cmd.ready = 1'b1;
            if (stat.req_valid) begin
               cmd.load = 1'b1;
               if (stat.req_opcode == OP_CELL) begin
                  step_in  = STEP_U0;
                  state_in = ST_ISSUE;
               end else if (stat.req_opcode == OP_FACE) begin
                  step_in  = STEP_A0;
                  state_in = ST_ISSUE;
               end
            end
         end
         ST_ISSUE: begin
            cmd.start = 1'b1;
            state_in  = ST_BUSY;
         end
         // write back and pick the next step
         ST_BUSY: begin
            if (stat.unit_done) begin
               cmd.wb = 1'b1;
               priority case (step_ff)
                  STEP_C: state_in = ST_IDLE;
                  STEP_CT: begin
                     if (stat.last_face) begin
                        step_in  = STEP_N;
                        state_in = ST_ISSUE;
                     end else begin
                        state_in = ST_IDLE;
                     end
                  end
                  STEP_DT: state_in = ST_OUT;
                  default: begin
                     step_in  = step_type'(5'(step_ff + 5'd1));
                     state_in = ST_ISSUE;
                  end
               endcase
            end
         end
         // hand the result to the response register
         ST_OUT: begin
            if (!stat.out_busy) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= STEP_U0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

endmodule

// ===== rtl/cfl_timestep_min_reduce.sv =====
// Top level of the CFL timestep min-reduce block: controller and datapath.
// Depends on cfl_tsr_pkg, cfl_tsr_if, cfl_tsr_ctrl and cfl_tsr_dpath.
//
//  port      | direction | handshake     | carries
//  req_if    | in        | valid/ready   | cell state, face area, clear request
//  rsp_if    | out       | valid/ready   | cell dt, running minimum, counted flag
//  csr_*     | in        | write enable  | gamma ratio, courant number
//
// A cell request runs 11 operations of the shared multiply/divide/root unit, a face
// 8, a last face 10. A clear request or opcode 3 starts no unit operation. Reset is
// synchronous and needs no clearing pass. A request is taken while a result waits in
// the response register; a last face stalls before its emit until that register is
// free.
module cfl_timestep_min_reduce #(
   parameter int VALUE_WIDTH = cfl_tsr_pkg::DEF_VALUE_WIDTH,
   parameter int FRAC_BITS   = cfl_tsr_pkg::DEF_FRAC_BITS
) (
   input  logic                                    clock,
   input  logic                                    reset,
   cfl_tsr_req_if.sink                             req_if,
   cfl_tsr_rsp_if.source                           rsp_if,
   input  logic                                    csr_write_en,
   input  logic [cfl_tsr_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [cfl_tsr_pkg::CSR_DATA_WIDTH-1:0]  csr_write_data
);
   import cfl_tsr_pkg::*;

   cmd_type    cmd;
   status_type stat;

   cfl_tsr_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .cmd   (cmd)
   );

   cfl_tsr_dpath #(.W(VALUE_WIDTH), .F(FRAC_BITS)) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .req_if         (req_if),
      .rsp_if         (rsp_if),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .cmd            (cmd),
      .stat           (stat)
   );

endmodule
